@@ sv/cct_pkg.sv @@
package cct_pkg;

    // Top values of the time units.
    localparam logic [5:0] SEC_MAX  = 6'd59;
    localparam logic [4:0] HOUR_MAX = 5'd23;

    // Menu modes.
    localparam logic [1:0] MODE_NORMAL    = 2'd0;
    localparam logic [1:0] MODE_SET_CLOCK = 2'd1;
    localparam logic [1:0] MODE_SET_TIMER = 2'd2;

    // Field selector codes.
    localparam logic [1:0] FIELD_HOURS   = 2'd0;
    localparam logic [1:0] FIELD_MINUTES = 2'd1;
    localparam logic [1:0] FIELD_SECONDS = 2'd2;

    // Reset values of the clock and the countdown.
    localparam logic [4:0] CLK_HOURS_RST   = 5'd22;
    localparam logic [5:0] CLK_MINUTES_RST = 6'd57;
    localparam logic [5:0] CLK_SECONDS_RST = 6'd50;
    localparam logic [4:0] CD_HOURS_RST    = 5'd0;
    localparam logic [5:0] CD_MINUTES_RST  = 6'd8;
    localparam logic [5:0] CD_SECONDS_RST  = 6'd12;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_hms;

    typedef struct packed {
        t_hms       clk;
        t_hms       cd;
        logic       run_flag;
        logic       heat_flag;
        logic [1:0] menu_mode;
        logic [1:0] clock_field;
        logic [1:0] timer_field;
    } t_state;

    typedef struct packed {
        logic run_toggle;
        logic heater_toggle;
        logic mode;
        logic field;
        logic up;
        logic down;
    } t_buttons;

    // Steps a three-way selector; any value of two or more returns to zero.
    function automatic logic [1:0] f_cycle3(input logic [1:0] v);
        return (v >= 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    // Increment with wraparound to zero at or above the top value.
    function automatic logic [5:0] f_wrap_up(input logic [5:0] v, input logic [5:0] top);
        return (v >= top) ? 6'd0 : v + 6'd1;
    endfunction

    // Decrement with wraparound from zero to the top value.
    function automatic logic [5:0] f_wrap_down(input logic [5:0] v, input logic [5:0] top);
        return (v == 6'd0) ? top : v - 6'd1;
    endfunction

    // Up then down on the selected field; an unknown selector adjusts nothing.
    function automatic t_hms f_adjust(input t_hms t, input logic [1:0] sel,
                                      input logic up, input logic down);
        t_hms r;
        r = t;
        if (up) begin
            case (sel)
                FIELD_SECONDS: r.seconds = f_wrap_up(r.seconds, SEC_MAX);
                FIELD_MINUTES: r.minutes = f_wrap_up(r.minutes, SEC_MAX);
                FIELD_HOURS:   r.hours   = 5'(f_wrap_up({1'b0, r.hours}, {1'b0, HOUR_MAX}));
                default: ;
            endcase
        end
        if (down) begin
            case (sel)
                FIELD_SECONDS: r.seconds = f_wrap_down(r.seconds, SEC_MAX);
                FIELD_MINUTES: r.minutes = f_wrap_down(r.minutes, SEC_MAX);
                FIELD_HOURS:   r.hours   = 5'(f_wrap_down({1'b0, r.hours}, {1'b0, HOUR_MAX}));
                default: ;
            endcase
        end
        return r;
    endfunction

    // One second forward with carries into minutes and hours.
    function automatic t_hms f_advance(input t_hms t);
        t_hms r;
        r = t;
        if (t.seconds < SEC_MAX) begin
            r.seconds = t.seconds + 6'd1;
        end else begin
            r.seconds = 6'd0;
            if (t.minutes < SEC_MAX) begin
                r.minutes = t.minutes + 6'd1;
            end else begin
                r.minutes = 6'd0;
                r.hours   = (t.hours >= HOUR_MAX) ? 5'd0 : t.hours + 5'd1;
            end
        end
        return r;
    endfunction

endpackage

@@ sv/clock_and_countdown_timer.sv @@
// A tick is first taken into the input register, then stepped into the state register
// that also holds the result; a stall on i_stall can hold it in the input register.
// Throughput: one tick per cycle while the result register is not stalled by i_stall.
// Reset (synchronous, i_rst_n low): clock 22:57:50, countdown 0:08:12, flags,
// menu mode and field selectors cleared, both pipeline stages emptied.
module clock_and_countdown_timer
    import cct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_run_toggle_pressed,
    input  logic       i_heater_toggle_pressed,
    input  logic       i_mode_pressed,
    input  logic       i_field_pressed,
    input  logic       i_up_pressed,
    input  logic       i_down_pressed,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [4:0] o_clock_hours,
    output logic [5:0] o_clock_minutes,
    output logic [5:0] o_clock_seconds,
    output logic [4:0] o_timer_hours,
    output logic [5:0] o_timer_minutes,
    output logic [5:0] o_timer_seconds,
    output logic       o_timer_running,
    output logic       o_heater_on,
    output logic       o_system_on,
    output logic [1:0] o_menu_mode_out,
    output logic [1:0] o_clock_field_out,
    output logic [1:0] o_timer_field_out
);

    logic     r_in_valid;
    t_buttons r_in_buttons;
    logic     r_out_valid;
    t_state   r_state;
    t_state   n_state;
    logic     out_free;
    logic     step_fire;
    logic     in_take;

    // Handshake between the input register and the state/result register.
    assign out_free  = ~r_out_valid | ~i_stall;
    assign step_fire = r_in_valid & out_free;
    assign o_stall   = r_in_valid & ~out_free;
    assign in_take   = i_valid & ~o_stall;

    // Input register: holds one tick until the state register can take it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_buttons <= '{run_toggle:    i_run_toggle_pressed,
                               heater_toggle: i_heater_toggle_pressed,
                               mode:          i_mode_pressed,
                               field:         i_field_pressed,
                               up:            i_up_pressed,
                               down:          i_down_pressed};
        end
    end

    // Next state for the tick in the input register.
    cct_step u_step (
        .i_state   (r_state),
        .i_buttons (r_in_buttons),
        .o_state   (n_state)
    );

    // State register doubles as the result register: it only moves when the
    // previous result has been taken, so it always shows the latest tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid         <= 1'b0;
            r_state.clk.hours   <= CLK_HOURS_RST;
            r_state.clk.minutes <= CLK_MINUTES_RST;
            r_state.clk.seconds <= CLK_SECONDS_RST;
            r_state.cd.hours    <= CD_HOURS_RST;
            r_state.cd.minutes  <= CD_MINUTES_RST;
            r_state.cd.seconds  <= CD_SECONDS_RST;
            r_state.run_flag    <= 1'b0;
            r_state.heat_flag   <= 1'b0;
            r_state.menu_mode   <= MODE_NORMAL;
            r_state.clock_field <= FIELD_HOURS;
            r_state.timer_field <= FIELD_HOURS;
        end else begin
            if (step_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result fields.
    assign o_valid           = r_out_valid;
    assign o_clock_hours     = r_state.clk.hours;
    assign o_clock_minutes   = r_state.clk.minutes;
    assign o_clock_seconds   = r_state.clk.seconds;
    assign o_timer_hours     = r_state.cd.hours;
    assign o_timer_minutes   = r_state.cd.minutes;
    assign o_timer_seconds   = r_state.cd.seconds;
    assign o_timer_running   = r_state.run_flag;
    assign o_heater_on       = r_state.heat_flag;
    assign o_system_on       = r_state.heat_flag & r_state.run_flag;
    assign o_menu_mode_out   = r_state.menu_mode;
    assign o_clock_field_out = r_state.clock_field;
    assign o_timer_field_out = r_state.timer_field;

endmodule

@@ sv/cct_step.sv @@
module cct_step
    import cct_pkg::*;
(
    input  t_state   i_state,
    input  t_buttons i_buttons,
    output t_state   o_state
);

    // Whole effect of one tick on the state, in the order the buttons are handled.
    always_comb begin
        o_state = i_state;

        // Flag toggles and the menu mode.
        if (i_buttons.run_toggle) begin
            o_state.run_flag = ~o_state.run_flag;
        end
        if (i_buttons.heater_toggle) begin
            o_state.heat_flag = ~o_state.heat_flag;
        end
        if (i_buttons.mode) begin
            o_state.menu_mode = f_cycle3(o_state.menu_mode);
        end

        // Field selection only applies in a set mode.
        if (o_state.menu_mode != MODE_NORMAL && i_buttons.field) begin
            if (o_state.menu_mode == MODE_SET_TIMER) begin
                o_state.timer_field = f_cycle3(o_state.timer_field);
            end else begin
                o_state.clock_field = f_cycle3(o_state.clock_field);
            end
        end

        // The clock runs except while it is being set; up and down go to the
        // clock in set-clock mode and to the countdown otherwise.
        if (o_state.menu_mode == MODE_NORMAL || o_state.menu_mode == MODE_SET_TIMER) begin
            o_state.clk = f_advance(o_state.clk);
            o_state.cd  = f_adjust(o_state.cd, o_state.timer_field,
                                   i_buttons.up, i_buttons.down);
        end else if (o_state.menu_mode == MODE_SET_CLOCK) begin
            o_state.clk = f_adjust(o_state.clk, o_state.clock_field,
                                   i_buttons.up, i_buttons.down);
        end

        // Countdown with borrow; at zero it stops and clears the run flag.
        if (o_state.run_flag) begin
            if (o_state.cd.seconds != 6'd0) begin
                o_state.cd.seconds = o_state.cd.seconds - 6'd1;
            end else if (o_state.cd.minutes != 6'd0) begin
                o_state.cd.minutes = o_state.cd.minutes - 6'd1;
                o_state.cd.seconds = SEC_MAX;
            end else if (o_state.cd.hours != 5'd0) begin
                o_state.cd.hours   = o_state.cd.hours - 5'd1;
                o_state.cd.minutes = SEC_MAX;
                o_state.cd.seconds = SEC_MAX;
            end else begin
                o_state.run_flag = 1'b0;
            end
        end
    end

endmodule
